// File: rtl/ir_thermometer_frame_check_macros.svh
// Assertion macros for the IR thermometer frame check.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef IR_THERMOMETER_FRAME_CHECK_MACROS_SVH
`define IR_THERMOMETER_FRAME_CHECK_MACROS_SVH

// same-cycle implication
`define IRTFC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IRTFC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/irtfc_pkg.sv
// Package for the IR thermometer frame check: status codes, limits and the
// SMBus PEC (CRC-8, poly 0x07) byte step. No dependencies.
package irtfc_pkg;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_BUS_FAIL       = 3'd1,
        ST_CHECK_MISMATCH = 3'd2,
        ST_ERROR_BIT      = 3'd3,
        ST_ZERO_VALUE     = 3'd4,
        ST_OUT_OF_RANGE   = 3'd5
    } status_t;

    localparam logic       CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic       CFG_COMMAND_CODE   = 1'b1;

    localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd90;
    localparam logic [7:0] COMMAND_CODE_RST   = 8'd7;

    localparam logic [7:0] CRC_POLY = 8'h07;

    // raw*2 - 27315 within [-7000, 38200] <=> raw within [10158, 32757]
    localparam logic [14:0] RAW_MIN = 15'd10158;
    localparam logic [14:0] RAW_MAX = 15'd32757;

    localparam logic signed [16:0] KELVIN_CENTI = 17'sd27315;
    localparam logic signed [16:0] FAIL_CENTI   = -17'sd27315;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: rtl/ir_thermometer_frame_check.sv
// IR thermometer frame check: top level, two register stages.
// Depends on irtfc_pkg and ir_thermometer_frame_check_macros.svh.
//
// One response beat is taken in every cycle (busy stays low). A beat taken
// with start high goes through the input stage, then the result stage: done
// is high for exactly one cycle and the receiver cannot stall it. The header
// part of the PEC (addresses and command) is formed in the input stage; the
// data bytes, the compare and the temperature checks sit in the result stage.
`include "ir_thermometer_frame_check_macros.svh"

module ir_thermometer_frame_check
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic               bus_failed,
    input  logic [7:0]         data_low,
    input  logic [7:0]         data_high,
    input  logic [7:0]         check_byte,
    output logic               done,
    output logic signed [16:0] temperature_centi,
    output logic [2:0]         status,
    output logic [7:0]         computed_check
);

    logic [6:0]  device_address_reg;
    logic [7:0]  command_code_reg;

    logic        in_valid_reg;
    logic        bus_failed_reg;
    logic [7:0]  data_low_reg;
    logic [7:0]  data_high_reg;
    logic [7:0]  check_byte_reg;
    logic [7:0]  prefix_crc_reg;
    logic [7:0]  prefix_crc_next;

    logic        done_reg;
    logic signed [16:0] temp_reg;
    logic signed [16:0] temp_next;
    irtfc_pkg::status_t status_reg;
    irtfc_pkg::status_t status_next;
    logic [7:0]  crc_reg;
    logic [7:0]  crc_next;

    logic [7:0]  waddr;
    logic [14:0] raw_value;
    logic signed [16:0] temp_calc;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= irtfc_pkg::DEVICE_ADDRESS_RST;
            command_code_reg   <= irtfc_pkg::COMMAND_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                irtfc_pkg::CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data[6:0];
                irtfc_pkg::CFG_COMMAND_CODE:   command_code_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign waddr = {device_address_reg, 1'b0};

    always_comb
    begin
        prefix_crc_next = irtfc_pkg::crc8_byte(8'h00, waddr);
        prefix_crc_next = irtfc_pkg::crc8_byte(prefix_crc_next, command_code_reg);
        prefix_crc_next = irtfc_pkg::crc8_byte(prefix_crc_next, waddr | 8'h01);
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            bus_failed_reg <= bus_failed;
            data_low_reg   <= data_low;
            data_high_reg  <= data_high;
            check_byte_reg <= check_byte;
            prefix_crc_reg <= prefix_crc_next;
        end
    end

    // result stage logic
    assign raw_value = {data_high_reg[6:0], data_low_reg};
    assign temp_calc = $signed({1'b0, raw_value, 1'b0}) - irtfc_pkg::KELVIN_CENTI;

    always_comb
    begin
        crc_next = irtfc_pkg::crc8_byte(prefix_crc_reg, data_low_reg);
        crc_next = irtfc_pkg::crc8_byte(crc_next, data_high_reg);
        temp_next = irtfc_pkg::FAIL_CENTI;
        if (bus_failed_reg)
            status_next = irtfc_pkg::ST_BUS_FAIL;
        else if (crc_next != check_byte_reg)
            status_next = irtfc_pkg::ST_CHECK_MISMATCH;
        else if (data_high_reg[7])
            status_next = irtfc_pkg::ST_ERROR_BIT;
        else if (raw_value == '0)
            status_next = irtfc_pkg::ST_ZERO_VALUE;
        else if (raw_value < irtfc_pkg::RAW_MIN || raw_value > irtfc_pkg::RAW_MAX)
            status_next = irtfc_pkg::ST_OUT_OF_RANGE;
        else
        begin
            status_next = irtfc_pkg::ST_OK;
            temp_next   = temp_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            temp_reg   <= temp_next;
            status_reg <= status_next;
            crc_reg    <= crc_next;
        end
    end

    assign done              = done_reg;
    assign temperature_centi = temp_reg;
    assign status            = status_reg;
    assign computed_check    = crc_reg;

    `IRTFC_ASSERT_NXT(a_result_follows, in_valid_reg, done, "accepted beat gave no result")
    `IRTFC_ASSERT_NXT(a_no_spurious, !in_valid_reg, !done, "result without accepted beat")
    `IRTFC_ASSERT_IMP(a_fail_temp, done && status != irtfc_pkg::ST_OK, temperature_centi == irtfc_pkg::FAIL_CENTI, "failure without fail temperature")
    `IRTFC_ASSERT_IMP(a_ok_range, done && status == irtfc_pkg::ST_OK, temperature_centi >= -17'sd7000 && temperature_centi <= 17'sd38200, "ok result out of range")

endmodule

// File: bench/testbench.sv
// Testbench for ir_thermometer_frame_check: sends sensor read responses under
// several register settings and checks every result against an in-bench PEC
// and temperature predictor. Depends on irtfc_pkg and the RTL top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOW_CENTI      = -7000;
    localparam int HIGH_CENTI     = 38200;
    localparam int PHASE_BEATS    = 325;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic signed [16:0] temp;
        irtfc_pkg::status_t status;
        logic [7:0]         pec;
    } reading_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = 1'b0;
    logic [7:0]         cfg_data = '0;
    logic               start = 1'b0;
    logic               busy;
    logic               bus_failed = 1'b0;
    logic [7:0]         data_low = '0;
    logic [7:0]         data_high = '0;
    logic [7:0]         check_byte = '0;
    logic               done;
    logic signed [16:0] temperature_centi;
    logic [2:0]         status;
    logic [7:0]         computed_check;

    logic [6:0] dev_addr = irtfc_pkg::DEVICE_ADDRESS_RST;
    logic [7:0] cmd_code = irtfc_pkg::COMMAND_CODE_RST;
    reading_t   expected_readings[$];
    int         mismatches = 0;
    int         quiet_cycles = 0;

    ir_thermometer_frame_check dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .start             (start),
        .busy              (busy),
        .bus_failed        (bus_failed),
        .data_low          (data_low),
        .data_high         (data_high),
        .check_byte        (check_byte),
        .done              (done),
        .temperature_centi (temperature_centi),
        .status            (status),
        .computed_check    (computed_check)
    );

    always #10 clk = ~clk;

    // CRC-8 over waddr, command, raddr, data_low, data_high, MSB first
    function automatic logic [7:0] pec_of(input logic [7:0] lo, input logic [7:0] hi);
        logic [39:0] msg;
        logic [7:0]  crc;
        logic        fb;
        msg = {dev_addr, 1'b0, cmd_code, dev_addr, 1'b1, lo, hi};
        crc = 8'h00;
        for (int i = 39; i >= 0; i--)
        begin
            fb  = crc[7] ^ msg[i];
            crc = {crc[6:0], 1'b0} ^ (fb ? irtfc_pkg::CRC_POLY : 8'h00);
        end
        return crc;
    endfunction

    function automatic reading_t predict_reading(input logic failed, input logic [7:0] lo,
                                                 input logic [7:0] hi, input logic [7:0] chk);
        reading_t    r;
        logic [15:0] raw;
        int          t;
        raw      = {hi, lo};
        r.pec    = pec_of(lo, hi);
        r.temp   = irtfc_pkg::FAIL_CENTI;
        r.status = irtfc_pkg::ST_OK;
        t        = int'(raw[14:0]) * 2 - int'(irtfc_pkg::KELVIN_CENTI);
        if (failed)
            r.status = irtfc_pkg::ST_BUS_FAIL;
        else if (r.pec != chk)
            r.status = irtfc_pkg::ST_CHECK_MISMATCH;
        else if (raw[15])
            r.status = irtfc_pkg::ST_ERROR_BIT;
        else if (raw[14:0] == 15'd0)
            r.status = irtfc_pkg::ST_ZERO_VALUE;
        else if (t < LOW_CENTI || t > HIGH_CENTI)
            r.status = irtfc_pkg::ST_OUT_OF_RANGE;
        else
            r.temp = t[16:0];
        return r;
    endfunction

    task automatic send_reading(input logic failed, input logic [7:0] lo,
                                input logic [7:0] hi, input logic [7:0] chk);
        start      <= 1'b1;
        bus_failed <= failed;
        data_low   <= lo;
        data_high  <= hi;
        check_byte <= chk;
        do
            @(posedge clk);
        while (busy);
        expected_readings.push_back(predict_reading(failed, lo, hi, chk));
    endtask

    // response with a matching check byte
    task automatic send_good(input logic [15:0] raw);
        send_reading(1'b0, raw[7:0], raw[15:8], pec_of(raw[7:0], raw[15:8]));
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == irtfc_pkg::CFG_DEVICE_ADDRESS)
            dev_addr = value[6:0];
        else
            cmd_code = value;
        @(posedge clk);
    endtask

    task automatic test_reset_values;
        send_good(16'd15483);
        send_reading(1'b1, 8'h8B, 8'h3C, pec_of(8'h8B, 8'h3C));
        send_reading(1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_reading(1'b0, 8'h8B, 8'h3C, pec_of(8'h8B, 8'h3C) ^ 8'h01);
        send_reading(1'b0, 8'h00, 8'h00, pec_of(8'h00, 8'h00) ^ 8'h80);
        send_good(16'h8000);
        send_good(16'hFFFF);
        send_good(16'h0000);
        send_good(16'h0001);
        send_good(16'd10157);
        send_good(16'd10158);
        send_good(16'd32757);
        send_good(16'd32758);
        send_good(16'h7FFF);
        drain();
    endtask

    task automatic test_config_extremes;
        write_reg(irtfc_pkg::CFG_DEVICE_ADDRESS, 8'h00);
        write_reg(irtfc_pkg::CFG_COMMAND_CODE, 8'h00);
        send_good(16'd20000);
        send_good(16'h0000);
        send_reading(1'b0, 8'h00, 8'h00, 8'h00);
        send_reading(1'b1, 8'h55, 8'hAA, 8'h00);
        drain();
        // top bit of the address write is dropped
        write_reg(irtfc_pkg::CFG_DEVICE_ADDRESS, 8'hFF);
        write_reg(irtfc_pkg::CFG_COMMAND_CODE, 8'hFF);
        send_good(16'd20000);
        send_good(16'h7FFF);
        send_reading(1'b0, 8'hFF, 8'hFF, 8'hFF);
        send_reading(1'b1, 8'h00, 8'h00, 8'hFF);
        drain();
    endtask

    task automatic send_random_reading;
        int          pick;
        logic [15:0] raw;
        logic [7:0]  chk;
        pick = $urandom_range(0, 99);
        raw  = 16'($urandom);
        if (pick < 8)
        begin
            chk = $urandom_range(0, 1) ? pec_of(raw[7:0], raw[15:8]) : 8'($urandom);
            send_reading(1'b1, raw[7:0], raw[15:8], chk);
        end
        else if (pick < 18)
        begin
            chk = pec_of(raw[7:0], raw[15:8]) ^ 8'($urandom_range(1, 255));
            send_reading(1'b0, raw[7:0], raw[15:8], chk);
        end
        else
        begin
            if (pick < 26)
                raw[15] = 1'b1;
            else if (pick < 30)
                raw = 16'h0000;
            else if (pick < 42)
                raw = 16'($urandom_range(1, 10157));
            else if (pick < 52)
                raw = 16'($urandom_range(32758, 32767));
            else
                raw = 16'($urandom_range(10158, 32757));
            send_good(raw);
        end
    endtask

    task automatic test_random_readings;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(irtfc_pkg::CFG_DEVICE_ADDRESS, 8'h00);
                    write_reg(irtfc_pkg::CFG_COMMAND_CODE, 8'hFF);
                end
                1:
                begin
                    write_reg(irtfc_pkg::CFG_DEVICE_ADDRESS, 8'h7F);
                    write_reg(irtfc_pkg::CFG_COMMAND_CODE, 8'h00);
                end
                2:
                begin
                    write_reg(irtfc_pkg::CFG_DEVICE_ADDRESS,
                              {1'b0, irtfc_pkg::DEVICE_ADDRESS_RST});
                    write_reg(irtfc_pkg::CFG_COMMAND_CODE, irtfc_pkg::COMMAND_CODE_RST);
                end
                default:
                begin
                    write_reg(irtfc_pkg::CFG_DEVICE_ADDRESS, 8'($urandom));
                    write_reg(irtfc_pkg::CFG_COMMAND_CODE, 8'($urandom));
                end
            endcase
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                send_random_reading();
                if (phase < 5 && $urandom_range(0, 4) == 0)
                    hold_off($urandom_range(1, 6));
            end
            drain();
        end
    endtask

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && done)
        begin
            if (expected_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: temp %0d status %0d pec %02h",
                             temperature_centi, status, computed_check);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (temperature_centi !== want.temp || status !== want.status
                    || computed_check !== want.pec)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%02h got %0d/%0d/%02h",
                                 want.temp, want.status, want.pec,
                                 temperature_centi, status, computed_check);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL ir_thermometer_frame_check");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_config_extremes();
        test_random_readings();
        drain();
        mismatches += expected_readings.size();
        if (mismatches == 0)
            $display("PASS ir_thermometer_frame_check");
        else
            $display("FAIL ir_thermometer_frame_check");
        $finish;
    end

endmodule
